/* src/first_fit_block_allocator_assert.svh */
// assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FFBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* src/ffba_pkg.sv */
// package for the first-fit block allocator: types, constants, state codes
package ffba_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int HEADER_BYTES = 12;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ITER_W = $clog2(TABLE_ENTRIES + 3);
    localparam logic [31:0] KERNEL_BASE = 32'h0010_0000;
    localparam logic [31:0] MAX_RAM_RESET = 32'h0200_0000;
    localparam logic [0:0] REG_MAX_RAM = 1'b0;
    localparam logic [0:0] REG_PKG_OFFSET = 1'b1;
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] alloc_size;
        logic [31:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_FSCAN, S_SHIFT, S_DONE
    } state_t;
endpackage

/* src/first_fit_block_allocator.sv */
// top level of the first-fit block allocator
// Usage: pulse start with req while busy is low; one result appears on rsp with
// done high for exactly one cycle. The receiver cannot stall, so nothing waits.
// cfg_we/cfg_idx/cfg_data write max_ram (index 0) and pkg_offset (index 1);
// the user must write them only while busy is low; the block does not enforce it.
// The region table sits in one synchronous ram (base and size per entry),
// with a fill count since valid entries always form a prefix.
// Allocate: each candidate is one pass over the table, reading one entry
// per cycle: the scan state covers the kernel region and then the entries,
// and a decide state ends the pass, with the collision test and lowest-base
// search in the same pass. Up to TABLE_ENTRIES+2 passes are made.
// Free: one pass to find the base, then a compaction that moves each later
// entry down one slot, reading it and then writing it.
// Table full allocates and kernel frees go straight to the done state.
// A new request is taken at the edge that ends the result cycle.
// Reset clears the fill count and restores the register defaults; no
// clearing pass is needed. One request is in work at a time.
module first_fit_block_allocator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ffba_pkg::req_t       req,
    output logic                 done,
    output ffba_pkg::rsp_t       rsp,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_idx,
    input  logic [31:0]          cfg_data
);
    localparam int IW = ffba_pkg::IDX_W;
    localparam int CW = ffba_pkg::CNT_W;

    ffba_pkg::state_t state_reg, state_next;
    logic [31:0] max_ram_reg;
    logic [23:0] pkg_offset_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;       // next read address
    logic          rv_reg, rv_next;         // read data valid this cycle
    logic [CW-1:0] rptr_reg, rptr_next;     // entry index of read data
    logic [32:0] cand_reg, cand_next;
    logic [32:0] size_reg, size_next;
    logic        coll_reg, coll_next;
    logic        found_reg, found_next;
    logic [32:0] lim_reg, lim_next;
    logic [33:0] nend_reg, nend_next;
    logic [ffba_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic        cmd_reg, cmd_next;
    logic [31:0] fa_reg, fa_next;
    logic [31:0] rb_reg, rb_next;
    ffba_pkg::rsp_t rsp_reg, rsp_next;
    logic        done_reg, done_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [64:0]   wdata, rdata;

    ffba_ram #(.WIDTH(65), .DEPTH(ffba_pkg::TABLE_ENTRIES), .AW(IW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // region seen this cycle: kernel when no ram data is valid in scan
    logic        use_kernel;
    logic [32:0] rg_b, rg_n;
    logic [33:0] rg_t, cand_e;
    logic        hit_coll, hit_low;
    logic [33:0] tot_end;

    assign busy = (state_reg != ffba_pkg::S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ram_reg    <= ffba_pkg::MAX_RAM_RESET;
            pkg_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                ffba_pkg::REG_MAX_RAM:    max_ram_reg <= cfg_data;
                ffba_pkg::REG_PKG_OFFSET: pkg_offset_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            rv_reg    <= rv_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        rptr_reg  <= rptr_next;
        cand_reg  <= cand_next;
        size_reg  <= size_next;
        coll_reg  <= coll_next;
        found_reg <= found_next;
        lim_reg   <= lim_next;
        nend_reg  <= nend_next;
        iter_reg  <= iter_next;
        cmd_reg   <= cmd_next;
        fa_reg    <= fa_next;
        rb_reg    <= rb_next;
        rsp_reg   <= rsp_next;
    end

    // region under test and its compare results
    always_comb
    begin
        use_kernel = !rv_reg;
        rg_b = use_kernel ? {1'b0, ffba_pkg::KERNEL_BASE} : {1'b0, rdata[64:33]};
        rg_n = use_kernel ? {9'b0, pkg_offset_reg} : rdata[32:0];
        rg_t = {1'b0, rg_b} + {1'b0, rg_n};
        cand_e = {1'b0, cand_reg} + {1'b0, size_reg};
        hit_coll = (({1'b0, cand_reg} >= {1'b0, rg_b}) && ({1'b0, cand_reg} < rg_t))
                || ((cand_e >= {1'b0, rg_b}) && (cand_e < rg_t))
                || (({1'b0, cand_reg} <= {1'b0, rg_b}) && (cand_e > rg_t));
        hit_low = (rg_b >= cand_reg) && (rg_b < lim_reg);
        tot_end = cand_e;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        rv_next    = 1'b0;
        rptr_next  = ptr_reg;
        cand_next  = cand_reg;
        size_next  = size_reg;
        coll_next  = coll_reg;
        found_next = found_reg;
        lim_next   = lim_reg;
        nend_next  = nend_reg;
        iter_next  = iter_reg;
        cmd_next   = cmd_reg;
        fa_next    = fa_reg;
        rb_next    = rb_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        we    = 1'b0;
        waddr = ptr_reg[IW-1:0];
        wdata = rdata;
        raddr = ptr_reg[IW-1:0];
        unique case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = req.cmd;
                    fa_next  = req.free_addr;
                    rb_next  = req.free_addr - 32'(ffba_pkg::HEADER_BYTES);
                    size_next = {1'b0, req.alloc_size} + 33'(ffba_pkg::HEADER_BYTES);
                    cand_next = {1'b0, ffba_pkg::KERNEL_BASE} + {9'b0, pkg_offset_reg};
                    iter_next = '0;
                    ptr_next  = '0;
                    raddr     = '0;
                    coll_next = 1'b0;
                    found_next = 1'b0;
                    lim_next  = {1'b0, max_ram_reg};
                    if (req.cmd == ffba_pkg::CMD_ALLOC)
                    begin
                        if (count_reg >= CW'(ffba_pkg::TABLE_ENTRIES))
                        begin
                            rsp_next = '{status: ffba_pkg::ST_FULL, addr: '0};
                            state_next = ffba_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = ffba_pkg::S_SCAN;
                        end
                    end
                    else if ((req.free_addr - 32'(ffba_pkg::HEADER_BYTES))
                             == ffba_pkg::KERNEL_BASE)
                    begin
                        rsp_next = '{status: ffba_pkg::ST_OK, addr: '0};
                        state_next = ffba_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ffba_pkg::S_FSCAN;
                    end
                end
            end
            ffba_pkg::S_SCAN:
            begin
                // kernel region first (no read data), then entries 0..count-1
                if (hit_coll)
                begin
                    coll_next = 1'b1;
                end
                if (hit_low)
                begin
                    lim_next   = rg_b;
                    nend_next  = rg_t;
                    found_next = 1'b1;
                end
                if (ptr_reg < count_reg)
                begin
                    raddr     = ptr_reg[IW-1:0];
                    rv_next   = 1'b1;
                    ptr_next  = ptr_reg + CW'(1);
                end
                else
                begin
                    // last region evaluated this cycle only if no more reads
                    if (!rv_reg || (rptr_reg + CW'(1) >= count_reg))
                    begin
                        state_next = ffba_pkg::S_DECIDE;
                    end
                end
                if (rv_reg)
                begin
                    rptr_next = rptr_reg + CW'(1);
                end
                else
                begin
                    rptr_next = '0;
                end
            end
            ffba_pkg::S_DECIDE:
            begin
                if (!coll_reg && (tot_end <= {2'b0, max_ram_reg}))
                begin
                    we    = 1'b1;
                    waddr = count_reg[IW-1:0];
                    wdata = {cand_reg[31:0], size_reg};
                    count_next = count_reg + CW'(1);
                    rsp_next = '{status: ffba_pkg::ST_OK,
                                 addr: cand_reg[31:0] + 32'(ffba_pkg::HEADER_BYTES)};
                    state_next = ffba_pkg::S_DONE;
                end
                else if (!found_reg || (nend_reg <= {1'b0, cand_reg})
                         || (iter_reg == ffba_pkg::ITER_W'(ffba_pkg::TABLE_ENTRIES + 1)))
                begin
                    rsp_next = '{status: ffba_pkg::ST_NO_SPACE, addr: '0};
                    state_next = ffba_pkg::S_DONE;
                end
                else
                begin
                    cand_next  = nend_reg[32:0];
                    iter_next  = iter_reg + ffba_pkg::ITER_W'(1);
                    ptr_next   = '0;
                    coll_next  = 1'b0;
                    found_next = 1'b0;
                    lim_next   = {1'b0, max_ram_reg};
                    state_next = ffba_pkg::S_SCAN;
                end
            end
            ffba_pkg::S_FSCAN:
            begin
                // rptr_reg tags the data arriving now
                if (rv_reg && (rdata[64:33] == rb_reg))
                begin
                    ptr_next   = rptr_reg;
                    state_next = ffba_pkg::S_SHIFT;
                end
                else if (ptr_reg < count_reg)
                begin
                    raddr    = ptr_reg[IW-1:0];
                    rv_next  = 1'b1;
                    rptr_next = ptr_reg;
                    ptr_next = ptr_reg + CW'(1);
                end
                else if (!rv_reg || (rptr_reg + CW'(1) >= count_reg))
                begin
                    rsp_next = '{status: ffba_pkg::ST_NOT_FOUND, addr: fa_reg};
                    state_next = ffba_pkg::S_DONE;
                end
                else
                begin
                    rptr_next = rptr_reg;
                end
            end
            ffba_pkg::S_SHIFT:
            begin
                // ptr_reg is the hole; read ptr+1 then write it into ptr
                if (ptr_reg + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    rsp_next = '{status: ffba_pkg::ST_OK, addr: '0};
                    state_next = ffba_pkg::S_DONE;
                end
                else if (!rv_reg)
                begin
                    raddr   = IW'(ptr_reg + CW'(1));
                    rv_next = 1'b1;
                end
                else
                begin
                    we    = 1'b1;
                    waddr = ptr_reg[IW-1:0];
                    wdata = rdata;
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            ffba_pkg::S_DONE:
            begin
                done_next  = 1'b1;
                state_next = ffba_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

`include "first_fit_block_allocator_assert.svh"

    `FFBA_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(ffba_pkg::TABLE_ENTRIES), "count overflow")
    `FFBA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
    `FFBA_ASSERT_IMPL(a_done_idle, done, !busy, "result while busy")
endmodule

/* src/ffba_ram.sv */
// generic single-port-write, one-read synchronous ram with registered read
module ffba_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
